### src/hbw_pkg.sv
package hbw_pkg;

   localparam int MAX_CLIENTS = 8;
   localparam int OP_W        = 2;
   localparam int ID_W        = 3;
   localparam int TS_W        = 32;
   localparam int CNT_W       = 32;
   localparam int MASK_W      = 8;
   localparam int STATUS_W    = 3;

   // req_tdata: client_slot, timeout_limit, required, time_now, padded to bytes
   localparam int REQ_FIELDS_W = ID_W + TS_W + 1 + TS_W;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   // rsp_tdata: status, late_mask, feed_grant, grant_count, denial_count
   localparam int RSP_FIELDS_W = STATUS_W + MASK_W + 1 + CNT_W + CNT_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_ENABLE = 1'b0;

   typedef enum logic [OP_W-1:0] {
      OP_REGISTER  = 2'd0,
      OP_HEARTBEAT = 2'd1,
      OP_CHECK     = 2'd2,
      OP_FEED      = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_INVALID   = 3'd1,
      ST_NOT_INIT  = 3'd2,
      ST_NOT_REG   = 3'd3,
      ST_NOT_READY = 3'd4,
      ST_EXPIRED   = 3'd5
   } status_type;

   typedef struct packed {
      logic              done;
      logic [MASK_W-1:0] found;
   } chk_status_type;

endpackage

### src/hbw_ram.sv
module hbw_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                                 clock,
   input  logic                                 we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                     wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                     rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### src/hbw_csr.sv
module hbw_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [hbw_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [hbw_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [hbw_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready,
   output logic                            enable
);

   logic enable_ff;
   logic enable_in;
   logic reg_idx;
   logic wr_en;

   assign reg_idx = csr_paddr[2];
   assign wr_en   = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      enable_in = enable_ff;
      if (wr_en && (reg_idx == hbw_pkg::CSR_IDX_ENABLE)) begin
         enable_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
      end else begin
         enable_ff <= enable_in;
      end
   end

   assign csr_prdata = (reg_idx == hbw_pkg::CSR_IDX_ENABLE) ?
                       hbw_pkg::CSR_DATA_W'(enable_ff) : '0;
   assign csr_pready = 1'b1;
   assign enable     = enable_ff;

endmodule

### src/hbw_check.sv
module hbw_check #(
   parameter int CLIENTS = hbw_pkg::MAX_CLIENTS,
   localparam int AW = (CLIENTS > 1) ? $clog2(CLIENTS) : 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [hbw_pkg::TS_W-1:0]    now,
   input  logic [CLIENTS-1:0]          active,
   input  logic [hbw_pkg::TS_W-1:0]    rd_timeout,
   input  logic [hbw_pkg::TS_W-1:0]    rd_beat,
   output logic [AW-1:0]               rd_addr,
   output hbw_pkg::chk_status_type     chk
);

   localparam int CW = $clog2(CLIENTS + 1);

   logic [CW-1:0]                issue_cnt_ff, issue_cnt_in;
   logic                         issuing_ff, issuing_in;
   logic                         eval_valid_ff, eval_valid_in;
   logic [AW-1:0]                eval_idx_ff, eval_idx_in;
   logic [CLIENTS-1:0]           found_ff, found_in;
   logic                         done_ff, done_in;
   logic [hbw_pkg::TS_W-1:0]     age;

   assign rd_addr = issue_cnt_ff[AW-1:0];
   assign age     = now - rd_beat;

   always_comb begin
      issue_cnt_in  = issue_cnt_ff;
      issuing_in    = issuing_ff;
      eval_valid_in = 1'b0;
      eval_idx_in   = eval_idx_ff;
      found_in      = found_ff;
      done_in       = 1'b0;

      // issue one slot read per cycle
      if (start) begin
         issue_cnt_in = '0;
         issuing_in   = 1'b1;
         found_in     = '0;
      end else if (issuing_ff) begin
         eval_valid_in = 1'b1;
         eval_idx_in   = issue_cnt_ff[AW-1:0];
         issue_cnt_in  = issue_cnt_ff + CW'(1);
         if (issue_cnt_ff == CW'(CLIENTS - 1)) begin
            issuing_in = 1'b0;
         end
      end

      // evaluate the slot whose read data has just returned
      if (eval_valid_ff) begin
         if (active[eval_idx_ff] && (age > rd_timeout)) begin
            found_in[eval_idx_ff] = 1'b1;
         end
         if (eval_idx_ff == AW'(CLIENTS - 1)) begin
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issuing_ff    <= 1'b0;
         eval_valid_ff <= 1'b0;
         done_ff       <= 1'b0;
      end else begin
         issuing_ff    <= issuing_in;
         eval_valid_ff <= eval_valid_in;
         done_ff       <= done_in;
      end
      issue_cnt_ff <= issue_cnt_in;
      eval_idx_ff  <= eval_idx_in;
      found_ff     <= found_in;
   end

   assign chk.done  = done_ff;
   assign chk.found = hbw_pkg::MASK_W'(found_ff);

endmodule

### src/multi_client_heartbeat_watchdog_top.sv
// Heartbeat watchdog supervisor for up to CLIENTS software clients.
// Request channel (req_*): one item per operation; req_tuser carries the
// operation (register, heartbeat, check, feed), req_tdata the arguments.
// Response channel (rsp_*): exactly one item per request, in order, with the
// status, expired mask, feed grant and the saturating grant/denial totals.
// Control port (csr_*): register 0 is the enable bit; with it clear every
// operation that passes its argument checks answers not-initialized.
// Timing: one item is worked on at a time. Register and heartbeat go from
// accept through EXEC to RESP; check and feed, unless disabled, also pass
// through SCAN, where the scan reads one client slot per cycle from the
// timeout and heartbeat memories.
// The next request is accepted in the cycle after the response is loaded.
// Stall: a response held by rsp_tready low blocks loading the next one;
// the block finishes its current item and then waits.
// Reset: synchronous and active high; clears enable, all client bits and
// both totals. No clearing pass runs: memory data is used only for
// clients that were registered and have sent a heartbeat since.
module multi_client_heartbeat_watchdog_top #(
   parameter int CLIENTS = hbw_pkg::MAX_CLIENTS
) (
   input  logic                            clock,
   input  logic                            reset,
   // request item
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [1:0] op
   input  logic [hbw_pkg::OP_W-1:0]        req_tuser,
   // [2:0] client_slot, [34:3] timeout_limit, [35] required, [67:36] time_now
   input  logic [hbw_pkg::REQ_DATA_W-1:0]  req_tdata,
   // response item
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [2:0] status, [10:3] late_mask, [11] feed_grant,
   // [43:12] grant_count, [75:44] denial_count
   output logic [hbw_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // control registers
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [hbw_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [hbw_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [hbw_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);

   localparam int AW    = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
   localparam int ID_W  = hbw_pkg::ID_W;
   localparam int TS_W  = hbw_pkg::TS_W;
   localparam int CNT_W = hbw_pkg::CNT_W;

   typedef enum logic [3:0] {
      IDLE = 4'b0001,
      EXEC = 4'b0010,
      SCAN = 4'b0100,
      RESP = 4'b1000
   } state_type;

   state_type                   state_ff, state_in;

   // latched request
   hbw_pkg::op_type             op_ff, op_in;
   logic [ID_W-1:0]             id_ff, id_in;
   logic [TS_W-1:0]             timeout_ff, timeout_in;
   logic                        required_ff, required_in;
   logic [TS_W-1:0]             now_ff, now_in;

   // client bookkeeping
   logic [CLIENTS-1:0]          registered_ff, registered_in;
   logic [CLIENTS-1:0]          required_bits_ff, required_bits_in;
   logic [CLIENTS-1:0]          seen_ff, seen_in;
   logic [CNT_W-1:0]            granted_ff, granted_in;
   logic [CNT_W-1:0]            denied_ff, denied_in;

   // result under construction and output register
   hbw_pkg::status_type         res_status_ff, res_status_in;
   logic [hbw_pkg::MASK_W-1:0]  res_mask_ff, res_mask_in;
   logic                        res_grant_ff, res_grant_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [hbw_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                        enable;
   logic                        id_ok;
   logic [AW-1:0]               slot;
   logic                        tm_we;
   logic                        hb_we;
   logic                        chk_start;
   logic [AW-1:0]               rd_addr;
   logic [TS_W-1:0]             rd_timeout;
   logic [TS_W-1:0]             rd_beat;
   hbw_pkg::chk_status_type     chk;
   hbw_pkg::status_type         chk_status;

   hbw_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .enable      (enable)
   );

   // Writes happen only in EXEC and scan reads are used only in SCAN, so the
   // sequencer keeps a write and a scan read from touching the same entry at once.
   hbw_ram #(
      .WIDTH (TS_W),
      .DEPTH (CLIENTS)
   ) u_timeout_ram (
      .clock (clock),
      .we    (tm_we),
      .waddr (slot),
      .wdata (timeout_ff),
      .raddr (rd_addr),
      .rdata (rd_timeout)
   );

   hbw_ram #(
      .WIDTH (TS_W),
      .DEPTH (CLIENTS)
   ) u_beat_ram (
      .clock (clock),
      .we    (hb_we),
      .waddr (slot),
      .wdata (now_ff),
      .raddr (rd_addr),
      .rdata (rd_beat)
   );

   hbw_check #(
      .CLIENTS (CLIENTS)
   ) u_check (
      .clock      (clock),
      .reset      (reset),
      .start      (chk_start),
      .now        (now_ff),
      .active     (required_bits_ff & seen_ff),
      .rd_timeout (rd_timeout),
      .rd_beat    (rd_beat),
      .rd_addr    (rd_addr),
      .chk        (chk)
   );

   assign slot  = id_ff[AW-1:0];
   assign id_ok = ({1'b0, id_ff} < (ID_W + 1)'(CLIENTS));

   // not ready outranks expired; the mask is reported either way
   always_comb begin
      if ((required_bits_ff & ~seen_ff) != '0) begin
         chk_status = hbw_pkg::ST_NOT_READY;
      end else if (chk.found != '0) begin
         chk_status = hbw_pkg::ST_EXPIRED;
      end else begin
         chk_status = hbw_pkg::ST_OK;
      end
   end

   always_comb begin
      state_in         = state_ff;
      op_in            = op_ff;
      id_in            = id_ff;
      timeout_in       = timeout_ff;
      required_in      = required_ff;
      now_in           = now_ff;
      registered_in    = registered_ff;
      required_bits_in = required_bits_ff;
      seen_in          = seen_ff;
      granted_in       = granted_ff;
      denied_in        = denied_ff;
      res_status_in    = res_status_ff;
      res_mask_in      = res_mask_ff;
      res_grant_in     = res_grant_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_data_in      = rsp_data_ff;
      tm_we            = 1'b0;
      hb_we            = 1'b0;
      chk_start        = 1'b0;

      // drop the response once taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         IDLE: begin
            if (req_tvalid) begin
               op_in       = hbw_pkg::op_type'(req_tuser);
               id_in       = req_tdata[ID_W-1:0];
               timeout_in  = req_tdata[ID_W +: TS_W];
               required_in = req_tdata[ID_W + TS_W];
               now_in      = req_tdata[ID_W + TS_W + 1 +: TS_W];
               state_in    = EXEC;
            end
         end
         EXEC: begin
            res_status_in = hbw_pkg::ST_OK;
            res_mask_in   = '0;
            res_grant_in  = 1'b0;
            state_in      = RESP;
            case (op_ff)
               hbw_pkg::OP_REGISTER: begin
                  if (!id_ok || (timeout_ff == '0)) begin
                     res_status_in = hbw_pkg::ST_INVALID;
                  end else if (!enable) begin
                     res_status_in = hbw_pkg::ST_NOT_INIT;
                  end else begin
                     tm_we                  = 1'b1;
                     registered_in[slot]    = 1'b1;
                     seen_in[slot]          = 1'b0;
                     required_bits_in[slot] = required_ff;
                  end
               end
               hbw_pkg::OP_HEARTBEAT: begin
                  if (!id_ok) begin
                     res_status_in = hbw_pkg::ST_INVALID;
                  end else if (!enable) begin
                     res_status_in = hbw_pkg::ST_NOT_INIT;
                  end else if (!registered_ff[slot]) begin
                     res_status_in = hbw_pkg::ST_NOT_REG;
                  end else begin
                     hb_we         = 1'b1;
                     seen_in[slot] = 1'b1;
                  end
               end
               hbw_pkg::OP_CHECK,
               hbw_pkg::OP_FEED: begin
                  if (!enable) begin
                     res_status_in = hbw_pkg::ST_NOT_INIT;
                  end else begin
                     chk_start = 1'b1;
                     state_in  = SCAN;
                  end
               end
               default: begin
                  res_status_in = hbw_pkg::ST_INVALID;
               end
            endcase
         end
         SCAN: begin
            // hold until the slot walk completes, then settle status, mask and, for a feed, the totals
            if (chk.done) begin
               res_status_in = chk_status;
               res_mask_in   = chk.found;
               if (op_ff == hbw_pkg::OP_FEED) begin
                  if (chk_status != hbw_pkg::ST_OK) begin
                     if (denied_ff != '1) begin
                        denied_in = denied_ff + CNT_W'(1);
                     end
                  end else begin
                     res_grant_in = 1'b1;
                     if (granted_ff != '1) begin
                        granted_in = granted_ff + CNT_W'(1);
                     end
                  end
               end
               state_in = RESP;
            end
         end
         RESP: begin
            // load the output register once it is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = hbw_pkg::RSP_DATA_W'({denied_ff, granted_ff, res_grant_ff,
                                                    res_mask_ff, res_status_ff});
               state_in     = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= IDLE;
         registered_ff    <= '0;
         required_bits_ff <= '0;
         seen_ff          <= '0;
         granted_ff       <= '0;
         denied_ff        <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         registered_ff    <= registered_in;
         required_bits_ff <= required_bits_in;
         seen_ff          <= seen_in;
         granted_ff       <= granted_in;
         denied_ff        <= denied_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      op_ff         <= op_in;
      id_ff         <= id_in;
      timeout_ff    <= timeout_in;
      required_ff   <= required_in;
      now_ff        <= now_in;
      res_status_ff <= res_status_in;
      res_mask_ff   <= res_mask_in;
      res_grant_ff  <= res_grant_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign req_tready = (state_ff == IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

### tb/sv/heartbeat_response_checker.sv
`timescale 1ns / 100ps

module heartbeat_response_checker
   import hbw_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   // [1:0] op
   input  logic [OP_W-1:0]        req_tuser,
   // [2:0] client_slot, [34:3] timeout_limit, [35] required, [67:36] time_now
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [2:0] status, [10:3] late_mask, [11] feed_grant,
   // [43:12] grant_count, [75:44] denial_count
   input  logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic                   csr_pready,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output int unsigned            mismatches,
   output int unsigned            outstanding,
   output int unsigned            responses_checked,
   output int unsigned            feeds_granted,
   output int unsigned            feeds_denied
);

   localparam int CLIENT_SLOTS = MAX_CLIENTS;
   localparam logic [CSR_ADDR_W-1:0] ENABLE_ADDR = CSR_ADDR_W'(4 * CSR_IDX_ENABLE);

   typedef struct {
      status_type        status;
      logic [MASK_W-1:0] mask;
      logic              grant;
      logic [CNT_W-1:0]  grants;
      logic [CNT_W-1:0]  denials;
   } watchdog_response_type;

   watchdog_response_type expected_responses[$];

   logic [TS_W-1:0]   timeout_mem [CLIENT_SLOTS];
   logic [TS_W-1:0]   beat_mem    [CLIENT_SLOTS];
   logic [MASK_W-1:0] registered_set;
   logic [MASK_W-1:0] required_set;
   logic [MASK_W-1:0] seen_set;
   logic [MASK_W-1:0] expired_set;
   logic [CNT_W-1:0]  grant_total;
   logic [CNT_W-1:0]  deny_total;
   logic              enabled;
   int unsigned       error_count;
   int unsigned       response_count;

   function automatic logic [CNT_W-1:0] saturating_inc(input logic [CNT_W-1:0] c);
      return (c == '1) ? c : c + 1'b1;
   endfunction

   // Walk every slot; stores the expired set as a side effect.
   function automatic status_type scan_clients(input logic [TS_W-1:0] now,
                                               output logic [MASK_W-1:0] found);
      logic [MASK_W-1:0] missing;
      logic [TS_W-1:0]   age;
      missing = required_set & ~seen_set;
      found   = '0;
      for (int k = 0; k < CLIENT_SLOTS; k++) begin
         age = now - beat_mem[k];
         if (required_set[k] && seen_set[k] && age > timeout_mem[k])
            found[k] = 1'b1;
      end
      expired_set = found;
      if (missing != '0)
         return ST_NOT_READY;
      if (found != '0)
         return ST_EXPIRED;
      return ST_OK;
   endfunction

   function automatic watchdog_response_type predict_response(input op_type op,
                                                              input logic [ID_W-1:0] id,
                                                              input logic [TS_W-1:0] tmo,
                                                              input logic req,
                                                              input logic [TS_W-1:0] now);
      watchdog_response_type r;
      logic [MASK_W-1:0] bit_sel;
      logic              id_ok;
      bit_sel  = MASK_W'(1) << id;
      id_ok    = int'(id) < CLIENT_SLOTS;
      r.status = ST_OK;
      r.mask   = '0;
      r.grant  = 1'b0;
      case (op)
         OP_REGISTER: begin
            if (!id_ok || tmo == '0) begin
               r.status = ST_INVALID;
            end else if (!enabled) begin
               r.status = ST_NOT_INIT;
            end else begin
               timeout_mem[id] = tmo;
               registered_set  = registered_set | bit_sel;
               seen_set        = seen_set & ~bit_sel;
               expired_set     = expired_set & ~bit_sel;
               required_set    = req ? (required_set | bit_sel) : (required_set & ~bit_sel);
            end
         end
         OP_HEARTBEAT: begin
            if (!id_ok) begin
               r.status = ST_INVALID;
            end else if (!enabled) begin
               r.status = ST_NOT_INIT;
            end else if ((registered_set & bit_sel) == '0) begin
               r.status = ST_NOT_REG;
            end else begin
               beat_mem[id] = now;
               seen_set     = seen_set | bit_sel;
               expired_set  = expired_set & ~bit_sel;
            end
         end
         OP_CHECK: begin
            if (!enabled)
               r.status = ST_NOT_INIT;
            else
               r.status = scan_clients(now, r.mask);
         end
         default: begin
            if (!enabled) begin
               r.status = ST_NOT_INIT;
            end else begin
               r.status = scan_clients(now, r.mask);
               if (r.status != ST_OK) begin
                  deny_total = saturating_inc(deny_total);
               end else begin
                  grant_total = saturating_inc(grant_total);
                  r.grant     = 1'b1;
               end
            end
         end
      endcase
      r.grants  = grant_total;
      r.denials = deny_total;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [CNT_W-1:0] got,
                                  input logic [CNT_W-1:0] want);
      error_count++;
      $display("[%0t] response %0d: %s got 0x%0h, expected 0x%0h",
               $realtime, response_count, what, got, want);
   endtask

   always @(posedge clock) begin
      watchdog_response_type want;
      if (reset) begin
         expected_responses.delete();
         for (int k = 0; k < CLIENT_SLOTS; k++) begin
            timeout_mem[k] = '0;
            beat_mem[k]    = '0;
         end
         registered_set = '0;
         required_set   = '0;
         seen_set       = '0;
         expired_set    = '0;
         grant_total    = '0;
         deny_total     = '0;
         enabled        = 1'b0;
         error_count    = 0;
         response_count = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr == ENABLE_ADDR)
            enabled = csr_pwdata[0];
         if (rsp_tvalid && rsp_tready) begin
            response_count++;
            if (expected_responses.size() == 0) begin
               report_mismatch("unexpected response, data", CNT_W'(rsp_tdata), '0);
            end else begin
               want = expected_responses.pop_front();
               if (rsp_tdata[2:0] !== want.status)
                  report_mismatch("status", CNT_W'(rsp_tdata[2:0]), CNT_W'(want.status));
               if (rsp_tdata[10:3] !== want.mask)
                  report_mismatch("late_mask", CNT_W'(rsp_tdata[10:3]), CNT_W'(want.mask));
               if (rsp_tdata[11] !== want.grant)
                  report_mismatch("feed_grant", CNT_W'(rsp_tdata[11]), CNT_W'(want.grant));
               if (rsp_tdata[43:12] !== want.grants)
                  report_mismatch("grant_count", rsp_tdata[43:12], want.grants);
               if (rsp_tdata[75:44] !== want.denials)
                  report_mismatch("denial_count", rsp_tdata[75:44], want.denials);
            end
         end
         if (req_tvalid && req_tready)
            expected_responses.push_back(predict_response(op_type'(req_tuser),
               req_tdata[2:0], req_tdata[34:3], req_tdata[35], req_tdata[67:36]));
      end
      mismatches        <= error_count;
      outstanding       <= expected_responses.size();
      responses_checked <= response_count;
      feeds_granted     <= grant_total;
      feeds_denied      <= deny_total;
   end

endmodule

### tb/sv/multi_client_heartbeat_watchdog_top_tb.sv
`timescale 1ns / 100ps

module multi_client_heartbeat_watchdog_top_tb;
   import hbw_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] ENABLE_ADDR = CSR_ADDR_W'(4 * CSR_IDX_ENABLE);
   localparam int PHASES      = 9;
   localparam int PHASE_ITEMS = 150;
   // leave headroom after a check or feed before touching the enable
   localparam int SETTLE_CYCLES = 24;

   // every input starts at a known value; reset is held from time zero
   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_tvalid  = 1'b0;
   logic                   req_tready;
   logic [OP_W-1:0]        req_tuser   = '0;        // [1:0] op
   // [2:0] client_slot, [34:3] timeout_limit, [35] required, [67:36] time_now
   logic [REQ_DATA_W-1:0]  req_tdata   = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready  = 1'b1;
   // [2:0] status, [10:3] late_mask, [11] feed_grant,
   // [43:12] grant_count, [75:44] denial_count
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_psel    = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_paddr   = '0;
   logic [CSR_DATA_W-1:0]  csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   int unsigned mismatches;
   int unsigned outstanding;
   int unsigned responses_checked;
   int unsigned feeds_granted;
   int unsigned feeds_denied;

   // stimulus-side bookkeeping, used only to shape the random traffic
   bit                idling     = 1'b1;
   bit                enabled_tb = 1'b0;
   logic [MASK_W-1:0] known_clients = '0;
   logic [ID_W-1:0]   beat_cursor   = '0;
   logic [TS_W-1:0]   now_ms        = '0;
   int unsigned       items_sent    = 0;
   int unsigned       stall_left    = 0;

   always #1 clock = ~clock;

   multi_client_heartbeat_watchdog_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   heartbeat_response_checker u_resp_check (
      .clock             (clock),
      .reset             (reset),
      .req_tvalid        (req_tvalid),
      .req_tready        (req_tready),
      .req_tuser         (req_tuser),
      .req_tdata         (req_tdata),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_tdata         (rsp_tdata),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_pready        (csr_pready),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .mismatches        (mismatches),
      .outstanding       (outstanding),
      .responses_checked (responses_checked),
      .feeds_granted     (feeds_granted),
      .feeds_denied      (feeds_denied)
   );

   // Receiver back-pressure: drop rsp_tready for random bursts while idling
   // is on, otherwise hold it high. One assignment per edge.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= (stall_left == 1);
      end else if (idling && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(1, 14);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Present one item and hold it until accepted. Within this task tvalid is only
   // lowered when a gap is inserted, so back-to-back items keep it high.
   task automatic send_item(input op_type op, input logic [ID_W-1:0] id,
                            input logic [TS_W-1:0] tmo, input logic req,
                            input logic [TS_W-1:0] ts);
      if (idling && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'b0, ts, req, tmo, id};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   // Drop the request, wait for every response, then let the block settle.
   task automatic drain;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Setup then access cycle; upper data bits are random and ignored.
   task automatic write_enable(input bit en);
      logic [CSR_DATA_W-1:0] wd;
      wd    = $urandom();
      wd[0] = en;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ENABLE_ADDR;
      csr_pwdata  <= wd;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      enabled_tb  = en;
   endtask

   // Mostly well-formed traffic: registrations with small timeouts, heartbeats
   // cycling over registered clients, checks and feeds on an advancing clock.
   // A small share is raw noise, zero timeouts and backward time jumps.
   task automatic send_random_op;
      logic [TS_W-1:0] tmo;
      logic [ID_W-1:0] id;
      logic            req;
      int unsigned     pick;
      pick = $urandom_range(0, 99);
      tmo  = $urandom();
      req  = 1'($urandom_range(0, 1));
      id   = ID_W'($urandom_range(0, 7));
      if ($urandom_range(0, 29) == 0)
         now_ms = $urandom();
      else
         now_ms = now_ms + $urandom_range(0, 8);
      if (pick < 5) begin
         send_item(op_type'($urandom_range(0, 3)), id, tmo, req, $urandom());
      end else if (pick < 17) begin
         case ($urandom_range(0, 11))
            0:       tmo = '0;
            1:       tmo = $urandom();
            default: tmo = $urandom_range(1, 300);
         endcase
         req = ($urandom_range(0, 3) != 0);
         if (tmo != '0 && enabled_tb)
            known_clients[id] = 1'b1;
         send_item(OP_REGISTER, id, tmo, req, $urandom());
      end else if (pick < 62) begin
         if (known_clients != '0 && $urandom_range(0, 1) == 0) begin
            for (int k = 0; k < MAX_CLIENTS; k++) begin
               beat_cursor = beat_cursor + 1'b1;
               if (known_clients[beat_cursor])
                  break;
            end
            id = beat_cursor;
         end
         send_item(OP_HEARTBEAT, id, tmo, req, now_ms);
      end else if (pick < 80) begin
         send_item(OP_CHECK, id, tmo, req, now_ms);
      end else begin
         send_item(OP_FEED, id, tmo, req, now_ms);
      end
   endtask

   // Hard stop if the handshakes ever lock up.
   initial begin
      #1000000;
      $display("multi_client_heartbeat_watchdog_top_tb: FAIL");
      $finish;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed: block disabled after reset ---
      send_item(OP_REGISTER,  3'd0, 32'd0,   1'b1, 32'd0);    // zero timeout wins over disable
      send_item(OP_REGISTER,  3'd0, 32'd100, 1'b1, 32'd0);
      send_item(OP_HEARTBEAT, 3'd0, 32'd0,   1'b0, 32'd5);
      send_item(OP_CHECK,     3'd0, 32'd0,   1'b0, 32'd5);
      send_item(OP_FEED,      3'd0, 32'd0,   1'b0, 32'd5);    // counts nothing
      drain();
      write_enable(1'b1);

      // --- directed: enabled ---
      send_item(OP_HEARTBEAT, 3'd7, 32'd0,          1'b0, 32'd0);  // never registered
      send_item(OP_CHECK,     3'd0, 32'd0,          1'b0, 32'd0);  // nobody to supervise
      send_item(OP_FEED,      3'd0, 32'd0,          1'b0, 32'd0);
      send_item(OP_REGISTER,  3'd0, 32'hFFFF_FFFF,  1'b1, 32'd0);
      send_item(OP_CHECK,     3'd0, 32'd0,          1'b0, 32'd5);  // required, never seen
      send_item(OP_FEED,      3'd0, 32'd0,          1'b0, 32'd5);
      send_item(OP_HEARTBEAT, 3'd0, 32'd0,          1'b0, 32'd0);
      // age equals the largest timeout: not expired
      send_item(OP_FEED,      3'd0, 32'd0,          1'b0, 32'hFFFF_FFFF);
      send_item(OP_REGISTER,  3'd7, 32'd1,          1'b1, 32'd0);
      send_item(OP_HEARTBEAT, 3'd7, 32'd0,          1'b0, 32'hFFFF_FFFF);
      // time wraps past zero: age two against a timeout of one
      send_item(OP_CHECK,     3'd0, 32'd0,          1'b0, 32'd1);
      send_item(OP_FEED,      3'd0, 32'd0,          1'b0, 32'd1);
      send_item(OP_REGISTER,  3'd3, 32'd10,         1'b0, 32'd0);  // optional client
      send_item(OP_HEARTBEAT, 3'd3, 32'd0,          1'b0, 32'd0);
      send_item(OP_REGISTER,  3'd5, 32'd50,         1'b1, 32'd0);
      // not ready beats expired, mask still reported
      send_item(OP_FEED,      3'd0, 32'd0,          1'b0, 32'd1);
      send_item(OP_HEARTBEAT, 3'd7, 32'd0,          1'b0, 32'd1);
      send_item(OP_HEARTBEAT, 3'd5, 32'd0,          1'b0, 32'd1);
      send_item(OP_FEED,      3'd0, 32'd0,          1'b0, 32'd2);
      send_item(OP_REGISTER,  3'd7, 32'd0,          1'b1, 32'd0);  // zero timeout, enabled
      send_item(OP_REGISTER,  3'd7, 32'd20,         1'b1, 32'd9);  // re-register clears seen
      send_item(OP_CHECK,     3'd0, 32'd0,          1'b0, 32'd3);
      known_clients = 8'hA9;
      now_ms        = 32'd3;

      // --- random phases; the enable is rewritten while idle ---
      for (int p = 0; p < PHASES; p++) begin
         drain();
         write_enable(!(p == 2 || p == 6));
         if (p == PHASES - 1)
            idling = 1'b0;
         for (int i = 0; i < PHASE_ITEMS; i++)
            send_random_op();
      end

      drain();
      $display("run covered %0d request items over %0d random phases, %0d responses checked",
               items_sent, PHASES, responses_checked);
      $display("feeds granted %0d, feeds denied %0d, items still awaited %0d",
               feeds_granted, feeds_denied, outstanding);
      if (mismatches == 0 && outstanding == 0)
         $display("multi_client_heartbeat_watchdog_top_tb: PASS");
      else
         $display("multi_client_heartbeat_watchdog_top_tb: FAIL");
      $finish;
   end

endmodule

### sim.f
src/hbw_pkg.sv
src/hbw_ram.sv
src/hbw_csr.sv
src/hbw_check.sv
src/multi_client_heartbeat_watchdog_top.sv
tb/sv/heartbeat_response_checker.sv
tb/sv/multi_client_heartbeat_watchdog_top_tb.sv
